// ===== hdl/sbusfr_pkg.sv =====
// Shared types and constants for the SBUS frame receiver.
// Used by the front, the frame queue, the channel emitter and the top level.
package sbusfr_pkg;

   // Frame layout
   localparam int unsigned FRAME_LAST_POS = 24;  // position of the end byte
   localparam int unsigned POS_W          = 5;
   localparam int unsigned DATA_BYTES     = 22;
   localparam int unsigned STORE_BYTES    = 23;  // data bytes plus flag byte
   localparam int unsigned FLAG_SLOT      = 22;
   localparam int unsigned DATA_BITS      = DATA_BYTES * 8;
   localparam int unsigned DATA_IDX_W     = $clog2(DATA_BITS);
   localparam int unsigned FAILSAFE_BIT   = 4;
   localparam int unsigned LOST_BIT       = 5;

   // Channel layout
   localparam int unsigned NUM_CHANNELS = 16;
   localparam int unsigned CHAN_IDX_W   = 4;
   localparam int unsigned CHAN_BITS    = 11;

   // Register file
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0]  CSR_START_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_END_BYTE   = 1'd1;
   localparam logic [CSR_DATA_W-1:0] START_BYTE_RST = 8'h0F;
   localparam logic [CSR_DATA_W-1:0] END_BYTE_RST   = 8'h00;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] start_byte;
      logic [CSR_DATA_W-1:0] end_byte;
   } cfg_type;

   // One good frame, ready for channel unpacking
   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      logic                 failsafe;
      logic                 lost_flag;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ===== hdl/sbusfr_front.sv =====
// Front of the SBUS frame receiver: hunts for the start byte, stores the frame,
// checks the end byte and pushes good frames. Depends on sbusfr_pkg.
module sbusfr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  sbusfr_pkg::cfg_type         cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   input  sbusfr_pkg::fifo_status_type fifo_status,
   output sbusfr_pkg::push_type        push
);

   logic [sbusfr_pkg::POS_W-1:0] pos_ff;
   logic [sbusfr_pkg::POS_W-1:0] pos_in;
   logic [sbusfr_pkg::POS_W-1:0] wr_idx;
   logic [7:0]                   store_ff [sbusfr_pkg::STORE_BYTES];
   logic [7:0]                   store_in;
   logic                         accept;
   logic                         at_end;
   logic                         wr_en;

   // Hold the end byte while the queue has no room
   always_comb begin
      at_end    = pos_ff >= sbusfr_pkg::POS_W'(sbusfr_pkg::FRAME_LAST_POS);
      req_stall = at_end && fifo_status.full;
      accept    = req_valid && !req_stall;
   end

   // Advance the frame position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_rx_byte == cfg.start_byte) begin
               pos_in = sbusfr_pkg::POS_W'(1);
            end
         end else if (!at_end) begin
            pos_in = pos_ff + sbusfr_pkg::POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Store data and flag bytes; the start byte itself is not needed
   always_comb begin
      store_in = req_rx_byte;
      wr_en    = accept && (pos_ff != '0) && !at_end;
      wr_idx   = pos_ff - sbusfr_pkg::POS_W'(1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sbusfr_pkg::STORE_BYTES; i++) begin
         if (wr_en && (wr_idx == sbusfr_pkg::POS_W'(i))) begin
            store_ff[i] <= store_in;
         end
      end
   end

   // Push the frame when the end byte matches, drop it otherwise
   always_comb begin
      push.valid = accept && at_end && (req_rx_byte == cfg.end_byte);
      for (int i = 0; i < sbusfr_pkg::DATA_BYTES; i++) begin
         push.frame.data[i*8 +: 8] = store_ff[i];
      end
      push.frame.failsafe  = store_ff[sbusfr_pkg::FLAG_SLOT][sbusfr_pkg::FAILSAFE_BIT];
      push.frame.lost_flag = store_ff[sbusfr_pkg::FLAG_SLOT][sbusfr_pkg::LOST_BIT];
   end

endmodule

// ===== hdl/sbusfr_fifo.sv =====
// Short frame queue between the front and the channel emitter.
// Depends on sbusfr_pkg for the frame and status types.
module sbusfr_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sbusfr_pkg::push_type        push,
   input  logic                        pop,
   output sbusfr_pkg::frame_type       head,
   output sbusfr_pkg::fifo_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sbusfr_pkg::frame_type slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      status.full  = count_ff == CNT_W'(DEPTH);
      status.empty = count_ff == '0;
      do_push      = push.valid && !status.full;
      do_pop       = pop && !status.empty;
      head         = slot_ff[rd_ptr_ff];
   end

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

// ===== hdl/sbusfr_emitter.sv =====
// Channel emitter: unpacks the queued frame into sixteen 11-bit channel results,
// one per cycle unless stalled, through an output register. Depends on sbusfr_pkg.
module sbusfr_emitter (
   input  logic                          clock,
   input  logic                          reset,
   input  sbusfr_pkg::frame_type         head,
   input  sbusfr_pkg::fifo_status_type   fifo_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbusfr_pkg::CHAN_IDX_W-1:0] rsp_channel_index,
   output logic [sbusfr_pkg::CHAN_BITS-1:0]  rsp_channel_value,
   output logic                          rsp_failsafe,
   output logic                          rsp_frame_lost,
   output logic                          rsp_last_channel
);

   logic [sbusfr_pkg::CHAN_IDX_W-1:0] chan_ff;
   logic [sbusfr_pkg::CHAN_IDX_W-1:0] chan_in;
   logic [sbusfr_pkg::DATA_IDX_W-1:0] bit_off;
   logic                              out_free;
   logic                              emit;
   logic                              last;
   logic                              valid_ff;
   logic                              valid_in;
   logic [sbusfr_pkg::CHAN_IDX_W-1:0] index_ff;
   logic [sbusfr_pkg::CHAN_BITS-1:0]  value_ff;
   logic [sbusfr_pkg::CHAN_BITS-1:0]  value_in;
   logic                              failsafe_ff;
   logic                              lost_ff;
   logic                              last_ff;

   // Emit one channel whenever the output register is free or being taken
   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      emit     = out_free && !fifo_status.empty;
      last     = chan_ff == sbusfr_pkg::CHAN_IDX_W'(sbusfr_pkg::NUM_CHANNELS - 1);
      pop      = emit && last;
      bit_off  = sbusfr_pkg::DATA_IDX_W'(chan_ff)
               * sbusfr_pkg::DATA_IDX_W'(sbusfr_pkg::CHAN_BITS);
      value_in = head.data[bit_off +: sbusfr_pkg::CHAN_BITS];
   end

   always_comb begin
      chan_in  = chan_ff;
      valid_in = valid_ff;
      if (emit) begin
         chan_in  = last ? '0 : chan_ff + sbusfr_pkg::CHAN_IDX_W'(1);
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         index_ff    <= chan_ff;
         value_ff    <= value_in;
         failsafe_ff <= head.failsafe;
         lost_ff     <= head.lost_flag;
         last_ff     <= last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_failsafe      = failsafe_ff;
   assign rsp_frame_lost    = lost_ff;
   assign rsp_last_channel  = last_ff;

endmodule

// ===== hdl/sbus_frame_receiver_top.sv =====
// On the end byte transfer the frame is written to the queue, and its first result
// then to the output register. A good frame gives sixteen results; bytes go in one per
// cycle; the end byte is held off only while the queue is full (FIFO_DEPTH frames).
// Reset: synchronous, clears frame position, queue and output valid; registers
// return to start byte 0x0F and end byte 0x00. No clearing pass is needed.
module sbus_frame_receiver_top #(
   parameter int unsigned FIFO_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [sbusfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbusfr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sbusfr_pkg::CHAN_IDX_W-1:0]  rsp_channel_index,
   output logic [sbusfr_pkg::CHAN_BITS-1:0]   rsp_channel_value,
   output logic                               rsp_failsafe,
   output logic                               rsp_frame_lost,
   output logic                               rsp_last_channel
);

   logic [sbusfr_pkg::CSR_DATA_W-1:0] start_byte_ff;
   logic [sbusfr_pkg::CSR_DATA_W-1:0] start_byte_in;
   logic [sbusfr_pkg::CSR_DATA_W-1:0] end_byte_ff;
   logic [sbusfr_pkg::CSR_DATA_W-1:0] end_byte_in;
   sbusfr_pkg::cfg_type               cfg;
   sbusfr_pkg::push_type              push;
   sbusfr_pkg::frame_type             head;
   sbusfr_pkg::fifo_status_type       fifo_status;
   logic                              pop;

   // Decode register writes
   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sbusfr_pkg::CSR_START_BYTE: start_byte_in = csr_write_data;
            sbusfr_pkg::CSR_END_BYTE:   end_byte_in   = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= sbusfr_pkg::START_BYTE_RST;
         end_byte_ff   <= sbusfr_pkg::END_BYTE_RST;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
      end
   end

   always_comb begin
      cfg.start_byte = start_byte_ff;
      cfg.end_byte   = end_byte_ff;
   end

   sbusfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .fifo_status (fifo_status),
      .push        (push)
   );

   sbusfr_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (fifo_status)
   );

   sbusfr_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .fifo_status       (fifo_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_lost    (rsp_frame_lost),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule

// ===== hdl/sbusfr_checker.sv =====
// Port-level checks for the SBUS frame receiver, bound to the top level.
// Depends on sbusfr_pkg for field widths.
module sbusfr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sbusfr_pkg::CHAN_IDX_W-1:0] rsp_channel_index,
   input logic [sbusfr_pkg::CHAN_BITS-1:0]  rsp_channel_value,
   input logic                              rsp_last_channel
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_channel_index) && $stable(rsp_channel_value)))
      else $error("stalled result changed");

   // Mark only channel 15 as last
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_last_channel == (rsp_channel_index ==
            sbusfr_pkg::CHAN_IDX_W'(sbusfr_pkg::NUM_CHANNELS - 1))))
      else $error("last marker does not match channel index");

   // Advance channels of a frame without gaps
   a_chan_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_channel) |=>
         (rsp_valid && (rsp_channel_index ==
            $past(rsp_channel_index) + sbusfr_pkg::CHAN_IDX_W'(1))))
      else $error("channel sequence broken inside a frame");

   // Drop output valid after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sbus_frame_receiver_top sbusfr_checker u_sbusfr_checker (.*);
